@@ rtl/core/value_noise_terrace_height_unit_assert.svh @@
// Assertion macros for the value noise terrace height unit.
// No dependencies; expects signals clock and reset in the using module.
`ifndef VALUE_NOISE_TERRACE_HEIGHT_UNIT_ASSERT_SVH
`define VALUE_NOISE_TERRACE_HEIGHT_UNIT_ASSERT_SVH

// same-cycle implication
`define VNTH_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vnth assertion failed");

// next-cycle implication
`define VNTH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vnth assertion failed");

`endif

@@ rtl/core/vnth_pkg.sv @@
// Package for the value noise terrace height unit: constants and helpers.
// No dependencies.
package vnth_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int NUM_STAGES     = 13;

   localparam logic [31:0] NOISE_SEED = 32'h51ED270B;
   localparam logic [31:0] MUL_X      = 32'd374761393;
   localparam logic [31:0] MUL_Z      = 32'd668265263;
   localparam logic [31:0] MUL_MIX    = 32'd1274126177;

   // reciprocal of 7 in Q14, exact for values below 2^11
   localparam logic [11:0] RECIP7     = 12'd2341;

   localparam logic [1:0] CSR_MAX_HEIGHT    = 2'd0;
   localparam logic [1:0] CSR_TERRACE_STEP  = 2'd1;
   localparam logic [1:0] CSR_TERRACE_ROUGH = 2'd2;

   localparam logic [7:0] MAX_HEIGHT_RST    = 8'd64;
   localparam logic [7:0] TERRACE_STEP_RST  = 8'd4;
   localparam logic [6:0] TERRACE_ROUGH_RST = 7'd1;

   function automatic logic [31:0] hash_pre(logic [31:0] px, logic [31:0] pz);
      logic [31:0] h;
      h = px + pz + NOISE_SEED;
      return h ^ (h >> 13);
   endfunction

   function automatic logic [23:0] hash_fin(logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      return t[31:8];
   endfunction

   // smoothstep weight in Q15 for period 2^s
   function automatic logic [15:0] smooth_q15(logic [4:0] f, int s);
      logic [31:0] v;
      v = 32'(f) * 32'(f) * ((32'd3 << s) - (32'(f) << 1));
      v = v << (15 - 3 * s);
      return v[15:0];
   endfunction

   // a + floor((b-a)*w / 2^15)
   function automatic logic [23:0] lerp24(logic [23:0] a, logic [23:0] b, logic [15:0] w);
      logic signed [24:0] d;
      logic signed [41:0] p;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, w});
      p = (p >>> 15) + $signed(42'(a));
      return p[23:0];
   endfunction

   // one restoring remainder step
   function automatic logic [7:0] rem_step(logic [7:0] r, logic b, logic [7:0] d);
      logic [8:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[7:0];
   endfunction

endpackage

@@ rtl/core/value_noise_terrace_height_unit.sv @@
// An accepted word strobes its height on rsp_strobe when it leaves stage 12 (terrace, roughen, clamp).
// Throughput: one word per cycle; busy is never raised, the pipeline never stalls.
// The rate is set by the 13-stage pipeline: hash multipliers, lerps, scaling, remainder.
// Reset (synchronous, active high) clears stage valids and loads register defaults.
// Uses vnth_pkg and value_noise_terrace_height_unit_assert.svh.
`include "value_noise_terrace_height_unit_assert.svh"

module value_noise_terrace_height_unit #(
   parameter int COORD_BITS = vnth_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // item word
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_cell_x,
   input  logic signed [COORD_BITS-1:0] req_cell_z,
   // result word
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_height,
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [7:0]                   csr_wdata
);
   import vnth_pkg::*;

   // ---------------- control/status registers ----------------
   logic [7:0] max_ff, step_ff;
   logic [6:0] rough_ff;
   logic [7:0] step_eff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_HEIGHT_RST;
         step_ff  <= TERRACE_STEP_RST;
         rough_ff <= TERRACE_ROUGH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_HEIGHT:    max_ff   <= csr_wdata;
            CSR_TERRACE_STEP:  step_ff  <= csr_wdata;
            CSR_TERRACE_ROUGH: rough_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // zero step means no terracing
   assign step_eff = (step_ff == 8'd0) ? 8'd1 : step_ff;

   // ---------------- valid chain ----------------
   logic [NUM_STAGES-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], start & ~busy};
      end
   end

   // ---------------- stage 0: sign extend ----------------
   logic [31:0] cx0_ff, cz0_ff;

   always_ff @(posedge clock) begin
      cx0_ff <= 32'(req_cell_x);
      cz0_ff <= 32'(req_cell_z);
   end

   // ---------------- stages 1..5: three octave lanes ----------------
   // lane 0: period 32, lane 1: period 16, lane 2: period 8
   logic [31:0] px1_ff [3][2];
   logic [31:0] pz1_ff [3][2];
   logic [15:0] wx1_ff [3], wz1_ff [3];
   logic [31:0] mx2_ff [3][2][2];   // [lane][x corner][z corner]
   logic [15:0] wx2_ff [3], wz2_ff [3];
   logic [23:0] n3_ff  [3][2][2];
   logic [15:0] wx3_ff [3], wz3_ff [3];
   logic [23:0] r4_ff  [3][2];      // x lerp at z0 and z0+1
   logic [15:0] wz4_ff [3];
   logic [23:0] o5_ff  [3];

   genvar o;
   generate
      for (o = 0; o < 3; o++) begin : g_oct
         localparam int SH = 5 - o;
         logic [31:0] xl, zl;

         assign xl = $signed(cx0_ff) >>> SH;
         assign zl = $signed(cz0_ff) >>> SH;

         always_ff @(posedge clock) begin
            px1_ff[o][0] <= xl * MUL_X;
            px1_ff[o][1] <= (xl + 32'd1) * MUL_X;
            pz1_ff[o][0] <= zl * MUL_Z;
            pz1_ff[o][1] <= (zl + 32'd1) * MUL_Z;
            wx1_ff[o]    <= smooth_q15(5'(cx0_ff & ((32'd1 << SH) - 32'd1)), SH);
            wz1_ff[o]    <= smooth_q15(5'(cz0_ff & ((32'd1 << SH) - 32'd1)), SH);

            for (int i = 0; i < 2; i++) begin
               for (int j = 0; j < 2; j++) begin
                  mx2_ff[o][i][j] <= hash_pre(px1_ff[o][i], pz1_ff[o][j]) * MUL_MIX;
                  n3_ff[o][i][j]  <= hash_fin(mx2_ff[o][i][j]);
               end
            end
            wx2_ff[o] <= wx1_ff[o];
            wz2_ff[o] <= wz1_ff[o];
            wx3_ff[o] <= wx2_ff[o];
            wz3_ff[o] <= wz2_ff[o];

            r4_ff[o][0] <= lerp24(n3_ff[o][0][0], n3_ff[o][1][0], wx3_ff[o]);
            r4_ff[o][1] <= lerp24(n3_ff[o][0][1], n3_ff[o][1][1], wx3_ff[o]);
            wz4_ff[o]   <= wz3_ff[o];

            o5_ff[o] <= lerp24(r4_ff[o][0], r4_ff[o][1], wz4_ff[o]);
         end
      end
   endgenerate

   // roughness hash rides alongside the lanes
   logic [31:0] pxc1_ff, pzc1_ff, mxc2_ff;
   logic [23:0] nc3_ff;
   logic [31:0] rp_in;
   logic [7:0]  rg4_ff, rg5_ff, rg6_ff;

   assign rp_in = 32'(nc3_ff) * 32'({rough_ff, 1'b1});

   always_ff @(posedge clock) begin
      pxc1_ff <= cx0_ff * MUL_X;
      pzc1_ff <= cz0_ff * MUL_Z;
      mxc2_ff <= hash_pre(pxc1_ff, pzc1_ff) * MUL_MIX;
      nc3_ff  <= hash_fin(mxc2_ff);
      rg4_ff  <= rp_in[31:24];
      rg5_ff  <= rg4_ff;
      rg6_ff  <= rg5_ff;
   end

   // ---------------- stage 6: weighted sum times max height ----------------
   logic [26:0] sum_in;
   logic [34:0] scl_in;
   logic [10:0] v6_ff;

   assign sum_in = {1'b0, o5_ff[0], 2'b00} + {2'b00, o5_ff[1], 1'b0} + {3'b000, o5_ff[2]};
   assign scl_in = 35'(sum_in) * 35'(max_ff);

   always_ff @(posedge clock) begin
      v6_ff <= scl_in[34:24];
   end

   // ---------------- stage 7: divide by seven ----------------
   logic [22:0] q7_in;
   logic [7:0]  hq_ff  [5];
   logic [7:0]  rem_ff [5];
   logic [7:0]  rg_ff  [5];

   assign q7_in = 23'(v6_ff) * 23'(RECIP7);

   always_ff @(posedge clock) begin
      hq_ff[0]  <= q7_in[21:14];
      rem_ff[0] <= 8'd0;
      rg_ff[0]  <= rg6_ff;
   end

   // ---------------- stages 8..11: remainder by step, two bits a stage ----------------
   genvar k;
   generate
      for (k = 1; k < 5; k++) begin : g_rem
         localparam int B = 9 - 2 * k;
         always_ff @(posedge clock) begin
            hq_ff[k]  <= hq_ff[k-1];
            rem_ff[k] <= rem_step(rem_step(rem_ff[k-1], hq_ff[k-1][B], step_eff),
                                  hq_ff[k-1][B-1], step_eff);
            rg_ff[k]  <= rg_ff[k-1];
         end
      end
   endgenerate

   // ---------------- stage 12: terrace, roughen, clamp ----------------
   logic [7:0]         base;
   logic signed [10:0] val;
   logic [7:0]         ht_in;
   logic [7:0]         ht_ff;

   assign base = hq_ff[4] - rem_ff[4];
   assign val  = $signed({3'b000, base}) + $signed({3'b000, rg_ff[4]})
               - $signed({4'b0000, rough_ff});

   always_comb begin
      if (val < 0) begin
         ht_in = 8'd0;
      end else if (val > $signed({3'b000, max_ff})) begin
         ht_in = max_ff;
      end else begin
         ht_in = val[7:0];
      end
   end

   always_ff @(posedge clock) begin
      ht_ff <= ht_in;
   end

   assign rsp_strobe = vld_ff[NUM_STAGES-1];
   assign rsp_height = ht_ff;

   // ---------------- assertions ----------------
   `VNTH_ASSERT_IMPL(a_clamp, rsp_strobe, rsp_height <= max_ff)
   `VNTH_ASSERT_IMPL(a_rem, vld_ff[11], rem_ff[4] < step_eff)
   `VNTH_ASSERT_IMPL(a_div7, vld_ff[7], (11'(hq_ff[0]) * 11'd7 <= $past(v6_ff)) && ($past(v6_ff) < 11'(hq_ff[0]) * 11'd7 + 11'd7))

endmodule
